// ----- design/stvlp_pkg.sv -----
`default_nettype none

package stvlp_pkg;

    // field widths
    localparam int unsigned BYTE_W    = 8;
    localparam int unsigned VALUE_W   = 31;
    localparam int unsigned TOKEN_W   = 4;
    localparam int unsigned ACC_EXT_W = VALUE_W + 4;

    // result beat: line_ok, three values, padded to whole bytes
    localparam int unsigned RESULT_W  = 1 + 3 * VALUE_W;
    localparam int unsigned M_TDATA_W = ((RESULT_W + 7) / 8) * 8;

    // defaults for the top level parameters
    localparam int unsigned DEF_LINE_LENGTH = 64;
    localparam int unsigned DEF_MAX_TOKENS  = 10;

    // tokens a good line carries
    localparam logic [TOKEN_W-1:0] GOOD_TOKENS = TOKEN_W'(3);

    // register reset and saturation limit
    localparam logic [VALUE_W-1:0]   MAX_VALUE_RESET = VALUE_W'(65535);
    localparam logic [VALUE_W-1:0]   SAT_MAX         = {VALUE_W{1'b1}};

    // character codes
    localparam logic [BYTE_W-1:0] CHAR_NUL   = 8'h00;
    localparam logic [BYTE_W-1:0] CHAR_TAB   = 8'h09;
    localparam logic [BYTE_W-1:0] CHAR_LF    = 8'h0A;
    localparam logic [BYTE_W-1:0] CHAR_VT    = 8'h0B;
    localparam logic [BYTE_W-1:0] CHAR_FF    = 8'h0C;
    localparam logic [BYTE_W-1:0] CHAR_CR    = 8'h0D;
    localparam logic [BYTE_W-1:0] CHAR_SPACE = 8'h20;
    localparam logic [BYTE_W-1:0] CHAR_PLUS  = 8'h2B;
    localparam logic [BYTE_W-1:0] CHAR_MINUS = 8'h2D;
    localparam logic [BYTE_W-1:0] CHAR_ZERO  = 8'h30;
    localparam logic [BYTE_W-1:0] CHAR_NINE  = 8'h39;
    localparam logic [BYTE_W-1:0] CHAR_SEMI  = 8'h3B;

    // number reading phase within a token
    typedef enum logic [1:0] {
        PH_SKIP   = 2'd0,
        PH_DIGITS = 2'd1,
        PH_DONE   = 2'd2
    } phase_t;

endpackage

`default_nettype wire

// ----- design/serial_triple_value_line_parser_core.sv -----
// channel  | dir | tdata fields (lsb first)                              | tuser/tlast
// s_*      | in  | rx_byte[7:0]                                          | none
// m_*      | out | line_ok, first_value, second_value, third_value, pad  | none
// cfg_*    | in  | max_value[30:0], written when cfg_wr_en is high       | none
//
// one character per cycle sustained, except when a line end waits on a stalled result register
// the beat is parsed from the input register, then a line end loads the result register
// rst_n clears the line state, max_value returns to 65535, no clearing pass is needed
// a stalled result holds the input register only when that beat also ends a line
`default_nettype none

module serial_triple_value_line_parser_core
#(
    parameter int unsigned LINE_LENGTH = stvlp_pkg::DEF_LINE_LENGTH,
    parameter int unsigned MAX_TOKENS  = stvlp_pkg::DEF_MAX_TOKENS
)
(
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    // fields: rx_byte[7:0]
    input  wire logic [stvlp_pkg::BYTE_W-1:0]     s_tdata,
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    // fields: line_ok[0], first_value[31:1], second_value[62:32], third_value[93:63], zeros
    output logic [stvlp_pkg::M_TDATA_W-1:0]       m_tdata,
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    input  wire logic                             cfg_wr_en,
    input  wire logic [stvlp_pkg::VALUE_W-1:0]    cfg_wr_data
);
    import stvlp_pkg::*;

    localparam int unsigned CC_W = $clog2(LINE_LENGTH + 1);

    // configuration register
    logic [VALUE_W-1:0] max_value_reg;

    // input register
    logic              in_valid_reg;
    logic [BYTE_W-1:0] in_byte_reg;

    // line state
    logic [CC_W-1:0]    char_count_reg,   char_count_next;
    logic [TOKEN_W-1:0] token_count_reg,  token_count_next;
    logic               inside_token_reg, inside_token_next;
    phase_t             phase_reg,        phase_next;
    logic               negative_reg,     negative_next;
    logic [VALUE_W-1:0] acc_reg,          acc_next;
    logic               truncated_reg,    truncated_next;
    logic [VALUE_W-1:0] pv_reg  [3];
    logic [VALUE_W-1:0] pv_next [3];

    // result register
    logic               m_valid_reg;
    logic               ok_reg,     ok_next;
    logic [VALUE_W-1:0] first_reg,  first_next;
    logic [VALUE_W-1:0] second_reg, second_next;
    logic [VALUE_W-1:0] third_reg,  third_next;

    // decode and datapath
    logic               is_term, is_semi, is_blank, is_sign, is_digit;
    logic               produce, advance, out_free;
    logic [ACC_EXT_W-1:0] acc_x10;
    logic [VALUE_W-1:0] acc_sat, clamped;
    logic [CC_W-1:0]    cc_inc;
    logic [1:0]         pv_idx;
    logic               pv_hit;
    logic               start;
    phase_t             phase_eff;

    // character classes
    always_comb
    begin
        is_term  = (in_byte_reg == CHAR_CR) || (in_byte_reg == CHAR_LF);
        is_semi  = (in_byte_reg == CHAR_SEMI);
        is_blank = (in_byte_reg == CHAR_TAB) || (in_byte_reg == CHAR_VT)
                || (in_byte_reg == CHAR_FF)  || (in_byte_reg == CHAR_SPACE);
        is_sign  = (in_byte_reg == CHAR_PLUS) || (in_byte_reg == CHAR_MINUS);
        is_digit = (in_byte_reg >= CHAR_ZERO) && (in_byte_reg <= CHAR_NINE);
    end

    // current token value, negatives to zero, clamped to max_value
    always_comb
    begin
        if (negative_reg)
            clamped = '0;
        else if (acc_reg > max_value_reg)
            clamped = max_value_reg;
        else
            clamped = acc_reg;
    end

    // slot of the current token among the first three
    always_comb
    begin
        pv_hit = (token_count_reg >= TOKEN_W'(1)) && (token_count_reg <= GOOD_TOKENS);
        pv_idx = 2'(token_count_reg - TOKEN_W'(1));
    end

    // multiply by ten and add the digit, saturating
    always_comb
    begin
        logic [VALUE_W-1:0] acc_base;
        acc_base = inside_token_reg ? acc_reg : '0;
        acc_x10  = {1'b0, acc_base, 3'b000} + {3'b000, acc_base, 1'b0}
                 + ACC_EXT_W'(in_byte_reg - CHAR_ZERO);
        acc_sat  = (acc_x10[ACC_EXT_W-1:VALUE_W] != '0) ? SAT_MAX : acc_x10[VALUE_W-1:0];
    end

    // token parse step
    always_comb
    begin
        token_count_next  = token_count_reg;
        inside_token_next = inside_token_reg;
        phase_next        = phase_reg;
        negative_next     = negative_reg;
        acc_next          = acc_reg;
        truncated_next    = truncated_reg;
        for (int i = 0; i < 3; i++)
            pv_next[i] = pv_reg[i];
        start     = !inside_token_reg;
        phase_eff = start ? PH_SKIP : phase_reg;

        if (in_byte_reg == CHAR_NUL)
        begin
            truncated_next = 1'b1;
        end
        else if (!truncated_reg)
        begin
            if (is_semi)
            begin
                if (inside_token_reg && pv_hit)
                    pv_next[pv_idx] = clamped;
                inside_token_next = 1'b0;
                phase_next        = PH_SKIP;
                negative_next     = 1'b0;
                acc_next          = '0;
            end
            else
            begin
                if (start)
                begin
                    inside_token_next = 1'b1;
                    negative_next     = 1'b0;
                    acc_next          = '0;
                    phase_next        = PH_SKIP;
                    if (token_count_reg < TOKEN_W'(MAX_TOKENS))
                        token_count_next = token_count_reg + TOKEN_W'(1);
                end
                unique case (phase_eff)
                    PH_SKIP:
                    begin
                        if (is_sign)
                        begin
                            negative_next = (in_byte_reg == CHAR_MINUS);
                            phase_next    = PH_DIGITS;
                        end
                        else if (is_digit)
                        begin
                            phase_next = PH_DIGITS;
                            acc_next   = acc_sat;
                        end
                        else if (!is_blank)
                        begin
                            phase_next = PH_DONE;
                        end
                    end
                    PH_DIGITS:
                    begin
                        if (is_digit)
                            acc_next = acc_sat;
                        else
                            phase_next = PH_DONE;
                    end
                    default:
                    begin
                        phase_next = phase_reg;
                    end
                endcase
            end
        end
    end

    // line end, result fields and line counter
    always_comb
    begin
        cc_inc          = char_count_reg + CC_W'(1);
        char_count_next = cc_inc;
        ok_next         = 1'b0;
        first_next      = '0;
        second_next     = '0;
        third_next      = '0;
        produce         = 1'b0;

        if (is_term)
        begin
            produce = 1'b1;
            ok_next = (token_count_reg == GOOD_TOKENS);
            if (ok_next)
            begin
                first_next  = pv_reg[0];
                second_next = pv_reg[1];
                third_next  = inside_token_reg ? clamped : pv_reg[2];
            end
        end
        else if (cc_inc >= CC_W'(LINE_LENGTH))
        begin
            produce = 1'b1;
        end
    end

    // handshake
    always_comb
    begin
        out_free = !m_valid_reg || m_tready;
        advance  = in_valid_reg && (!produce || out_free);
        s_tready = !in_valid_reg || advance;
    end

    // configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            max_value_reg <= MAX_VALUE_RESET;
        else if (cfg_wr_en)
            max_value_reg <= cfg_wr_data;
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_tvalid && s_tready)
            in_valid_reg <= 1'b1;
        else if (advance)
            in_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
            in_byte_reg <= s_tdata;
    end

    // line state update, cleared at every line end
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            char_count_reg   <= '0;
            token_count_reg  <= '0;
            inside_token_reg <= 1'b0;
            phase_reg        <= PH_SKIP;
            negative_reg     <= 1'b0;
            acc_reg          <= '0;
            truncated_reg    <= 1'b0;
            for (int i = 0; i < 3; i++)
                pv_reg[i] <= '0;
        end
        else if (advance)
        begin
            if (produce)
            begin
                char_count_reg   <= '0;
                token_count_reg  <= '0;
                inside_token_reg <= 1'b0;
                phase_reg        <= PH_SKIP;
                negative_reg     <= 1'b0;
                acc_reg          <= '0;
                truncated_reg    <= 1'b0;
                for (int i = 0; i < 3; i++)
                    pv_reg[i] <= '0;
            end
            else
            begin
                char_count_reg   <= char_count_next;
                token_count_reg  <= token_count_next;
                inside_token_reg <= inside_token_next;
                phase_reg        <= phase_next;
                negative_reg     <= negative_next;
                acc_reg          <= acc_next;
                truncated_reg    <= truncated_next;
                for (int i = 0; i < 3; i++)
                    pv_reg[i] <= pv_next[i];
            end
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_valid_reg <= 1'b0;
        else if (advance && produce)
            m_valid_reg <= 1'b1;
        else if (m_tready)
            m_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance && produce)
        begin
            ok_reg     <= ok_next;
            first_reg  <= first_next;
            second_reg <= second_next;
            third_reg  <= third_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = M_TDATA_W'({third_reg, second_reg, first_reg, ok_reg});

    // a bad line carries zero values
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_valid_reg && !ok_reg) |-> (first_reg == '0 && second_reg == '0 && third_reg == '0))
        else $error("bad line result carries nonzero values");

    // line counter never reaches the line length
    assert property (@(posedge clk) disable iff (!rst_n)
        char_count_reg < CC_W'(LINE_LENGTH))
        else $error("character count overran the line length");

    // token count saturates at its limit
    assert property (@(posedge clk) disable iff (!rst_n)
        token_count_reg <= TOKEN_W'(MAX_TOKENS))
        else $error("token count above its limit");

    // a line end blocked by a full result register keeps its beat
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && produce && !out_free) |=> (in_valid_reg && $stable(in_byte_reg)))
        else $error("line end beat lost while result stalled");

endmodule

`default_nettype wire

// ----- sim/tb_top.sv -----
`default_nettype none

module tb_top;

    import stvlp_pkg::*;

    localparam int unsigned LINE_LEN       = DEF_LINE_LENGTH;
    localparam int unsigned TOK_LIMIT      = DEF_MAX_TOKENS;
    localparam int unsigned WATCHDOG_LIMIT = 3000;
    localparam int unsigned HOLD_CYCLES    = 300;
    localparam int unsigned SETTLE_CYCLES  = 6;
    localparam int unsigned PHASE_BYTES    = 125;

    // one character waiting to be sent, optionally held until all results are in
    typedef struct {
        logic [BYTE_W-1:0] ch;
        bit                drain;
    } rx_item_t;

    // one line verdict as the block should report it
    typedef struct {
        logic               ok;
        logic [VALUE_W-1:0] val [3];
    } line_result_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    logic [BYTE_W-1:0]    s_tdata     = '0;
    logic                 s_tvalid    = 1'b0;
    logic                 s_tready;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 m_tvalid;
    logic                 m_tready    = 1'b0;
    logic                 cfg_wr_en   = 1'b0;
    logic [VALUE_W-1:0]   cfg_wr_data = '0;

    // character stream and expected line results
    rx_item_t     rx_q [$];
    line_result_t pending_lines [$];
    int unsigned  rx_queued    = 0;
    int unsigned  rx_accepted  = 0;
    int unsigned  lines_seen   = 0;
    int unsigned  mismatch_count = 0;
    bit           drain_next   = 1'b0;
    bit           no_idle      = 1'b0;
    bit           hold_req     = 1'b0;

    // parser state mirror
    logic [VALUE_W-1:0] clamp_limit = MAX_VALUE_RESET;
    int unsigned        line_chars;
    int unsigned        tok_count;
    bit                 in_token;
    bit                 neg_sign;
    bit                 rx_trunc;
    phase_t             num_phase;
    logic [VALUE_W-1:0] num_acc;
    logic [VALUE_W-1:0] tok_val [3];

    // driver and monitor working variables
    bit          drv_offer;
    rx_item_t    drv_item;
    int unsigned send_gap;
    bit          mon_ready;
    int unsigned stall_left;
    int unsigned hold_left;
    bit          hold_taken;
    int unsigned quiet_cycles = 0;

    serial_triple_value_line_parser_core
    #(
        .LINE_LENGTH (LINE_LEN),
        .MAX_TOKENS  (TOK_LIMIT)
    )
    u_top
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tdata     (s_tdata),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .m_tdata     (m_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    always #1 clk = ~clk;

    function automatic bit is_digit(input logic [BYTE_W-1:0] c);
        return (c >= CHAR_ZERO) && (c <= CHAR_NINE);
    endfunction

    // idle length: mostly none or short, now and then long
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    task automatic clear_line_state();
        line_chars = 0;
        tok_count  = 0;
        in_token   = 1'b0;
        neg_sign   = 1'b0;
        rx_trunc   = 1'b0;
        num_phase  = PH_SKIP;
        num_acc    = '0;
        for (int i = 0; i < 3; i++)
            tok_val[i] = '0;
    endtask

    // finish the current token, store it if it is one of the first three
    task automatic close_number();
        logic [VALUE_W-1:0] v;
        if (in_token)
        begin
            v = neg_sign ? '0 : num_acc;
            if (v > clamp_limit)
                v = clamp_limit;
            if (tok_count >= 1 && tok_count <= 3)
                tok_val[tok_count-1] = v;
        end
        in_token  = 1'b0;
        num_phase = PH_SKIP;
        neg_sign  = 1'b0;
        num_acc   = '0;
    endtask

    // atoi-style scan of one character inside the line
    task automatic take_token_char(input logic [BYTE_W-1:0] c);
        longint unsigned wide;
        if (c == CHAR_SEMI)
        begin
            close_number();
            return;
        end
        if (!in_token)
        begin
            in_token  = 1'b1;
            num_phase = PH_SKIP;
            neg_sign  = 1'b0;
            num_acc   = '0;
            if (tok_count < TOK_LIMIT)
                tok_count++;
        end
        if (num_phase == PH_SKIP)
        begin
            if (c == CHAR_TAB || c == CHAR_VT || c == CHAR_FF || c == CHAR_SPACE)
                return;
            if (c == CHAR_PLUS || c == CHAR_MINUS)
            begin
                neg_sign  = (c == CHAR_MINUS);
                num_phase = PH_DIGITS;
                return;
            end
            if (is_digit(c))
                num_phase = PH_DIGITS;
            else
            begin
                num_phase = PH_DONE;
                return;
            end
        end
        if (num_phase == PH_DIGITS)
        begin
            if (is_digit(c))
            begin
                wide = 64'(num_acc) * 64'd10 + 64'(c - CHAR_ZERO);
                num_acc = (wide > SAT_MAX) ? SAT_MAX : wide[VALUE_W-1:0];
            end
            else
                num_phase = PH_DONE;
        end
    endtask

    // predict the effect of one accepted character
    task automatic parse_rx_char(input logic [BYTE_W-1:0] c);
        line_result_t r;
        if (c == CHAR_CR || c == CHAR_LF)
        begin
            close_number();
            r.ok = (tok_count == GOOD_TOKENS);
            for (int i = 0; i < 3; i++)
                r.val[i] = r.ok ? tok_val[i] : '0;
            pending_lines.push_back(r);
            clear_line_state();
            return;
        end
        if (c == CHAR_NUL)
            rx_trunc = 1'b1;
        else if (!rx_trunc)
            take_token_char(c);
        line_chars++;
        // overlong line ends here with an invalid verdict
        if (line_chars >= LINE_LEN)
        begin
            r.ok = 1'b0;
            for (int i = 0; i < 3; i++)
                r.val[i] = '0;
            pending_lines.push_back(r);
            clear_line_state();
        end
    endtask

    task automatic report_mismatch(input string field, input longint unsigned got,
                                   input longint unsigned want);
        $display("mismatch on result %0d, %s: got 0x%0h, want 0x%0h",
                 lines_seen, field, got, want);
        mismatch_count++;
    endtask

    // compare one result beat against the oldest expectation
    task automatic check_line_result();
        line_result_t       want;
        logic [VALUE_W-1:0] got_val [3];
        string              names [3];
        names[0] = "first_value";
        names[1] = "second_value";
        names[2] = "third_value";
        lines_seen++;
        if (pending_lines.size() == 0)
        begin
            report_mismatch("unexpected result", 64'(m_tdata[0]), 64'd0);
            return;
        end
        want = pending_lines.pop_front();
        got_val[0] = m_tdata[VALUE_W:1];
        got_val[1] = m_tdata[2*VALUE_W:VALUE_W+1];
        got_val[2] = m_tdata[3*VALUE_W:2*VALUE_W+1];
        if (m_tdata[0] !== want.ok)
            report_mismatch("line_ok", 64'(m_tdata[0]), 64'(want.ok));
        for (int i = 0; i < 3; i++)
            if (got_val[i] !== want.val[i])
                report_mismatch(names[i], 64'(got_val[i]), 64'(want.val[i]));
        if (m_tdata[M_TDATA_W-1:RESULT_W] !== '0)
            report_mismatch("pad", 64'(m_tdata[M_TDATA_W-1:RESULT_W]), 64'd0);
    endtask

    // stimulus building
    task automatic push_char(input logic [BYTE_W-1:0] c);
        rx_item_t it;
        it.ch      = c;
        it.drain   = drain_next;
        drain_next = 1'b0;
        rx_q.push_back(it);
        rx_queued++;
    endtask

    task automatic push_text(input string s);
        for (int i = 0; i < s.len(); i++)
            push_char(s[i]);
    endtask

    task automatic push_blank();
        case ($urandom_range(0, 3))
            0: push_char(CHAR_TAB);
            1: push_char(CHAR_VT);
            2: push_char(CHAR_FF);
            default: push_char(CHAR_SPACE);
        endcase
    endtask

    task automatic push_terminator();
        push_char($urandom_range(0, 1) ? CHAR_CR : CHAR_LF);
    endtask

    // one token: blanks, sign, digits and junk in random mix
    task automatic gen_token();
        int unsigned r;
        int unsigned nd;
        int unsigned p;
        r = $urandom_range(0, 99);
        if ($urandom_range(0, 99) < 25)
            repeat ($urandom_range(1, 2)) push_blank();
        if (r < 8)
        begin
            // junk before any digit
            push_char(BYTE_W'($urandom_range(8'h41, 8'h7A)));
            repeat ($urandom_range(0, 2))
                push_char(BYTE_W'($urandom_range(CHAR_ZERO, CHAR_NINE)));
            return;
        end
        p = $urandom_range(0, 99);
        if (p < 15)
            push_char(CHAR_MINUS);
        else if (p < 25)
            push_char(CHAR_PLUS);
        if (r < 14)
            nd = 0;
        else if ($urandom_range(0, 99) < 12)
            nd = $urandom_range(9, 12);
        else
            nd = $urandom_range(1, 5);
        repeat (nd) push_char(BYTE_W'($urandom_range(CHAR_ZERO, CHAR_NINE)));
        if ($urandom_range(0, 99) < 10)
        begin
            case ($urandom_range(0, 2))
                0: push_char(BYTE_W'($urandom_range(8'h41, 8'h7A)));
                1: push_char(CHAR_SPACE);
                default: push_char(8'hFF);
            endcase
            if ($urandom_range(0, 1))
                push_char(BYTE_W'($urandom_range(CHAR_ZERO, CHAR_NINE)));
        end
    endtask

    // one line: mostly three tokens, the rest wrong counts, noise and long lines
    task automatic gen_line();
        int unsigned kind;
        int unsigned n_tok;
        int unsigned nul_at;
        int unsigned n;
        int unsigned r;
        logic [BYTE_W-1:0] c;
        if ($urandom_range(0, 99) < 4)
            drain_next = 1'b1;
        kind = $urandom_range(0, 99);
        if (kind < 75 || kind >= 92)
        begin
            if (kind < 65 || kind >= 92)
                n_tok = 3;
            else
            begin
                n_tok = $urandom_range(0, 13);
                if (n_tok == 3)
                    n_tok = 4;
            end
            nul_at = (kind >= 92) ? $urandom_range(0, 3) : 99;
            if ($urandom_range(0, 99) < 15)
                push_char(CHAR_SEMI);
            for (int t = 0; t < n_tok; t++)
            begin
                if (t == nul_at)
                    push_char(CHAR_NUL);
                gen_token();
                if (t + 1 < n_tok)
                begin
                    push_char(CHAR_SEMI);
                    if ($urandom_range(0, 99) < 20)
                        push_char(CHAR_SEMI);
                end
            end
            if (nul_at == 3 || (nul_at < 3 && nul_at >= n_tok))
                push_char(CHAR_NUL);
            if ($urandom_range(0, 99) < 10)
                push_char(CHAR_SEMI);
            push_terminator();
        end
        else if (kind < 85)
        begin
            // raw noise over the whole byte range
            n = $urandom_range(1, 20);
            repeat (n) push_char(BYTE_W'($urandom_range(0, 255)));
            push_terminator();
        end
        else
        begin
            // line close to or past the length limit
            n = $urandom_range(LINE_LEN - 2, LINE_LEN + 12);
            repeat (n)
            begin
                r = $urandom_range(0, 99);
                if (r < 50)
                    c = BYTE_W'($urandom_range(CHAR_ZERO, CHAR_NINE));
                else if (r < 70)
                    c = CHAR_SEMI;
                else if (r < 80)
                    c = CHAR_SPACE;
                else
                    c = BYTE_W'($urandom_range(0, 255));
                if (c == CHAR_CR || c == CHAR_LF)
                    c = CHAR_SEMI;
                push_char(c);
            end
            if ($urandom_range(0, 1))
                push_terminator();
        end
    endtask

    task automatic gen_phase(input int unsigned target);
        int unsigned start;
        start = rx_queued;
        while (rx_queued - start < target)
            gen_line();
    endtask

    // everything sent and every result back, then let the pipeline settle
    task automatic wait_idle();
        while (rx_accepted != rx_queued || pending_lines.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_limit(input logic [VALUE_W-1:0] v);
        @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        clamp_limit = v;
    endtask

    // input driver: one beat per handshake, gaps drawn after each beat
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            send_gap = 0;
        end
        else
        begin
            drv_offer = s_tvalid;
            if (s_tvalid && s_tready)
            begin
                parse_rx_char(s_tdata);
                rx_accepted++;
                drv_offer = 1'b0;
            end
            if (!drv_offer)
            begin
                if (send_gap > 0)
                    send_gap--;
                else if (rx_q.size() != 0 && !(rx_q[0].drain && pending_lines.size() != 0))
                begin
                    drv_item = rx_q.pop_front();
                    s_tdata <= drv_item.ch;
                    drv_offer = 1'b1;
                    send_gap = no_idle ? 0 : pick_gap();
                end
            end
            s_tvalid <= drv_offer;
        end
    end

    // result monitor with random stalls and one long hold-off
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            stall_left = 0;
            hold_left  = 0;
            hold_taken = 1'b0;
        end
        else
        begin
            if (m_tvalid && m_tready)
                check_line_result();
            if (hold_left > 0)
            begin
                hold_left--;
                mon_ready = 1'b0;
            end
            else if (hold_req && !hold_taken)
            begin
                hold_taken = 1'b1;
                hold_left  = HOLD_CYCLES;
                mon_ready  = 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                mon_ready = 1'b0;
            end
            else
            begin
                mon_ready = 1'b1;
                if (!no_idle)
                    stall_left = pick_gap();
            end
            m_tready <= mon_ready;
        end
    end

    // watchdog on cycles with no beat on either side
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("watchdog: no beat for %0d cycles, %0d results outstanding",
                         quiet_cycles, pending_lines.size());
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    // reset, directed lines, then random phases under several clamp limits
    initial
    begin
        clear_line_state();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // empty line
        push_char(CHAR_LF);
        // skipped empty tokens, negative, sign only, junk first
        push_text(";;-5;+;x");
        push_char(CHAR_CR);
        // all blank kinds, saturation, trailing junk, zero byte cutting the text
        push_char(CHAR_TAB);
        push_char(CHAR_VT);
        push_char(CHAR_FF);
        push_text(" 9999999999;7");
        push_char(8'hFF);
        push_text(";1");
        push_char(CHAR_NUL);
        push_text(";5");
        push_char(CHAR_LF);
        wait_idle();

        // widest limit, first line waits for a drained pipeline
        write_limit(SAT_MAX);
        drain_next = 1'b1;
        gen_phase(PHASE_BYTES);
        wait_idle();

        // zero limit, receiver backs off for a long stretch
        write_limit('0);
        gen_phase(PHASE_BYTES);
        hold_req = 1'b1;
        wait_idle();

        // small limit so clamping is common
        write_limit(VALUE_W'($urandom_range(1, 300)));
        gen_phase(PHASE_BYTES);
        wait_idle();

        // random limit, full rate on both sides
        no_idle = 1'b1;
        write_limit(VALUE_W'($urandom_range(1, 32'h7FFF_FFFE)));
        gen_phase(PHASE_BYTES);
        wait_idle();
        no_idle = 1'b0;

        write_limit(MAX_VALUE_RESET);
        gen_phase(PHASE_BYTES);
        wait_idle();

        repeat (20) @(posedge clk);
        if (mismatch_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

`default_nettype wire
